FILE: design/lr_pkg.sv
// lr_pkg: shared types and constants for the line rasterizer.
// Transfer payload structs, per-line state struct and register indexes.
// No dependencies.
package lr_pkg;

    localparam int COORD_BITS  = 16;
    localparam int CANVAS_BITS = 15;
    // signed coordinate difference, and the D term
    localparam int DELTA_BITS  = COORD_BITS + 1;
    localparam int ERR_BITS    = COORD_BITS + 3;
    localparam int CMP_BITS    = (COORD_BITS > CANVAS_BITS) ? COORD_BITS : CANVAS_BITS;

    localparam logic [CANVAS_BITS-1:0] CANVAS_RESET = CANVAS_BITS'(800);

    localparam logic CFG_CANVAS_WIDTH  = 1'b0;
    localparam logic CFG_CANVAS_HEIGHT = 1'b1;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    typedef struct packed {
        logic                         req_type;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic                         visible;
        logic                         last;
    } t_out_item;

    typedef struct packed {
        logic                  x_major;
        logic [COORD_BITS-1:0] cur_x;
        logic [COORD_BITS-1:0] cur_y;
        logic [ERR_BITS-1:0]   error_term;
        logic [DELTA_BITS-1:0] steps_left;
        logic [DELTA_BITS-1:0] major_delta;
        logic [DELTA_BITS-1:0] minor_delta;
        logic                  minor_negative;
        logic [COORD_BITS-1:0] stop_x;
        logic [COORD_BITS-1:0] stop_y;
    } t_line;

endpackage

FILE: design/lr_setup.sv
// lr_setup: turns a start request's endpoints into the initial walk state.
// Orders endpoints along the major axis and forms the deltas and D term.
// Depends on lr_pkg.
module lr_setup (
    input  lr_pkg::t_in_item i_item,
    output lr_pkg::t_line    o_line
);
    import lr_pkg::*;

    logic signed [DELTA_BITS-1:0] ax, ay, bx, by;
    logic signed [DELTA_BITS-1:0] dx, dy, adx, ady, sdx, sdy;
    logic signed [DELTA_BITS-1:0] major, minor, minor_abs;
    logic                         x_major, swap, minor_neg;

    always_comb begin
        ax  = DELTA_BITS'(i_item.start_x);
        ay  = DELTA_BITS'(i_item.start_y);
        bx  = DELTA_BITS'(i_item.end_x);
        by  = DELTA_BITS'(i_item.end_y);
        dx  = bx - ax;
        dy  = by - ay;
        adx = dx[DELTA_BITS-1] ? -dx : dx;
        ady = dy[DELTA_BITS-1] ? -dy : dy;
        x_major = (ady <= adx);
        swap    = x_major ? dx[DELTA_BITS-1] : dy[DELTA_BITS-1];
        sdx     = swap ? -dx : dx;
        sdy     = swap ? -dy : dy;
        major   = x_major ? sdx : sdy;
        minor   = x_major ? sdy : sdx;
        minor_neg = minor[DELTA_BITS-1];
        minor_abs = minor_neg ? -minor : minor;

        o_line.x_major        = x_major;
        o_line.major_delta    = major;
        o_line.minor_delta    = minor_abs;
        o_line.minor_negative = minor_neg;
        o_line.steps_left     = major;
        o_line.error_term     = (ERR_BITS'(minor_abs) << 1) - ERR_BITS'(major);
        o_line.cur_x          = swap ? i_item.end_x   : i_item.start_x;
        o_line.cur_y          = swap ? i_item.end_y   : i_item.start_y;
        o_line.stop_x         = swap ? i_item.start_x : i_item.end_x;
        o_line.stop_y         = swap ? i_item.start_y : i_item.end_y;
    end

endmodule

FILE: design/lr_walk.sv
// lr_walk: line state registers and the per-tick Bresenham step.
// Emits one pixel per accepted tick while a line runs; flags visibility.
// Depends on lr_pkg and lr_setup.
module lr_walk (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  lr_pkg::t_in_item                 i_item,
    input  logic [lr_pkg::CANVAS_BITS-1:0]   i_canvas_w,
    input  logic [lr_pkg::CANVAS_BITS-1:0]   i_canvas_h,
    output logic                             o_push,
    output lr_pkg::t_out_item                o_pix
);
    import lr_pkg::*;

    logic                  r_active, n_active;
    t_line                 r_line, n_line;
    t_line                 setup_line;
    logic                  is_end, err_pos;
    logic [COORD_BITS-1:0] px, py, inc;
    logic [ERR_BITS-1:0]   d_min, d_diff;

    lr_setup u_setup (
        .i_item (i_item),
        .o_line (setup_line)
    );

    always_comb begin
        is_end  = (r_line.steps_left == '0);
        err_pos = !r_line.error_term[ERR_BITS-1] && (r_line.error_term != '0);
        inc     = r_line.minor_negative ? '1 : COORD_BITS'(1);
        d_min   = ERR_BITS'(r_line.minor_delta) << 1;
        d_diff  = (ERR_BITS'(r_line.minor_delta) - ERR_BITS'(r_line.major_delta)) << 1;
        px      = is_end ? r_line.stop_x : r_line.cur_x;
        py      = is_end ? r_line.stop_y : r_line.cur_y;

        o_push        = i_accept && (i_item.req_type == REQ_TICK) && r_active;
        o_pix.pixel_x = px;
        o_pix.pixel_y = py;
        o_pix.last    = is_end;
        o_pix.visible = !px[COORD_BITS-1] && !py[COORD_BITS-1]
                        && (CMP_BITS'(px) < CMP_BITS'(i_canvas_w))
                        && (CMP_BITS'(py) < CMP_BITS'(i_canvas_h));

        n_active = r_active;
        n_line   = r_line;
        if (i_accept && (i_item.req_type == REQ_START)) begin
            n_active = 1'b1;
            n_line   = setup_line;
        end else if (o_push) begin
            if (is_end) begin
                n_active = 1'b0;
            end else begin
                if (err_pos) begin
                    if (r_line.x_major) begin
                        n_line.cur_y = r_line.cur_y + inc;
                    end else begin
                        n_line.cur_x = r_line.cur_x + inc;
                    end
                    n_line.error_term = r_line.error_term + d_diff;
                end else begin
                    n_line.error_term = r_line.error_term + d_min;
                end
                if (r_line.x_major) begin
                    n_line.cur_x = r_line.cur_x + COORD_BITS'(1);
                end else begin
                    n_line.cur_y = r_line.cur_y + COORD_BITS'(1);
                end
                n_line.steps_left = r_line.steps_left - DELTA_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_line   <= '0;
        end else begin
            r_active <= n_active;
            r_line   <= n_line;
        end
    end

    // the end point closes the line
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_pix.last) |=> !r_active)
        else $error("line still active after last pixel");

    // an inner pixel needs steps left to walk
    a_inner_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && !o_pix.last) |=> (r_line.steps_left == $past(r_line.steps_left) - 1'b1))
        else $error("step count did not advance");

endmodule

FILE: design/lr_out.sv
// lr_out: output register with a skid stage for the pixel channel.
// Keeps the input side accepting while a pixel waits downstream.
// Depends on lr_pkg.
module lr_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lr_pkg::t_out_item i_pix,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output lr_pkg::t_out_item o_pix
);
    import lr_pkg::*;

    logic      r_out_valid, r_skid_valid;
    t_out_item r_out, r_skid;

    assign o_space = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_pix   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            if (r_out_valid && !i_ready) begin
                r_skid       <= i_pix;
                r_skid_valid <= 1'b1;
            end else begin
                r_out        <= i_pix;
                r_out_valid  <= 1'b1;
            end
        end else if (i_ready) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a pixel ahead of the output register");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_valid)
        else $error("pixel pushed into a full buffer");

endmodule

FILE: design/line_rasterizer_core.sv
// line_rasterizer_core: top level of the Bresenham line rasterizer.
// Holds the canvas registers; instantiates lr_walk and lr_out. Depends on lr_pkg.
//
//   channel  direction  handshake              payload
//   in       input      i_in_valid/o_in_ready  lr_pkg::t_in_item
//   out      output     o_out_valid/i_out_ready lr_pkg::t_out_item
//   cfg      input      i_cfg_we               i_cfg_index, i_cfg_data
//
// One request per cycle while o_in_ready is high; each pixel is registered in lr_out.
// The step (one add and compare on D) sets the rate: one pixel per clock while ticks
// are accepted. Two-entry buffering keeps o_in_ready high until the skid fills.
// Synchronous active-low reset: line idle, canvas 800 x 800.
module line_rasterizer_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  lr_pkg::t_in_item               i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output lr_pkg::t_out_item              o_out,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [lr_pkg::CANVAS_BITS-1:0] i_cfg_data
);
    import lr_pkg::*;

    logic [CANVAS_BITS-1:0] r_canvas_w, r_canvas_h;
    logic                   accept, push, space;
    t_out_item              pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_w <= CANVAS_RESET;
            r_canvas_h <= CANVAS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CANVAS_WIDTH:  r_canvas_w <= i_cfg_data;
                CFG_CANVAS_HEIGHT: r_canvas_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_ready = space;
    assign accept     = i_in_valid && space;

    lr_walk u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_in),
        .i_canvas_w (r_canvas_w),
        .i_canvas_h (r_canvas_h),
        .o_push     (push),
        .o_pix      (pix)
    );

    lr_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pix   (pix),
        .o_space (space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_pix   (o_out)
    );

endmodule
